// ===== src/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants
// Sample, configuration and pipeline types of the PID controller with
// settle detection.
// ----------------------------------------------------------------------------
package psd_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_GAIN_P          = 3'd0;
  localparam logic [2:0] REG_GAIN_I          = 3'd1;
  localparam logic [2:0] REG_GAIN_D          = 3'd2;
  localparam logic [2:0] REG_INTEGRAL_WINDOW = 3'd3;
  localparam logic [2:0] REG_SETTLE_BAND     = 3'd4;
  localparam logic [2:0] REG_SETTLE_MS       = 3'd5;
  localparam logic [2:0] REG_TIMEOUT_MS      = 3'd6;
  localparam logic [2:0] REG_MAX_OUTPUT      = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Reset value of the drive limit: 127.0 in Q15.8.
  localparam logic [22:0] MAX_OUTPUT_RST = 23'd32512;

  // Timer step per control tick and timer ceiling, in ms.
  localparam logic [15:0] TICK_MS   = 16'd10;
  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  typedef logic signed [23:0] err_t;
  typedef logic signed [23:0] drive_t;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [22:0] integral_window;
    logic [22:0] settle_band;
    logic [15:0] settle_ms;
    logic [15:0] timeout_ms;
    logic [22:0] max_output;
  } cfg_t;

  // Result of the state update stage, handed to the drive arithmetic.
  typedef struct packed {
    logic signed [23:0] err;
    logic signed [31:0] integ;
    logic signed [24:0] diff;
    logic               done;
  } upd_t;

endpackage

// ===== src/psd_in_if.sv =====
// ----------------------------------------------------------------------------
// psd_in_if: error sample channel
// Valid/ready channel that carries one error sample and its restart bit.
// ----------------------------------------------------------------------------
interface psd_in_if import psd_pkg::*; ();

  logic valid;
  logic ready;
  err_t error_sample;
  logic restart;

  modport source (output valid, output error_sample, output restart, input ready);
  modport sink   (input valid, input error_sample, input restart, output ready);

endinterface

// ===== src/psd_out_if.sv =====
// ----------------------------------------------------------------------------
// psd_out_if: drive result channel
// Valid/ready channel that carries the drive value and the settled flag.
// ----------------------------------------------------------------------------
interface psd_out_if import psd_pkg::*; ();

  logic   valid;
  logic   ready;
  drive_t drive_value;
  logic   settled;

  modport source (output valid, output drive_value, output settled, input ready);
  modport sink   (input valid, input drive_value, input settled, output ready);

endinterface

// ===== src/psd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// psd_cfg_regs: configuration registers
// Holds gains, windows, times and the drive limit written by index.
// ----------------------------------------------------------------------------
module psd_cfg_regs import psd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_GAIN_P:          cfg_nxt.gain_p          = cfg_wdata[15:0];
        REG_GAIN_I:          cfg_nxt.gain_i          = cfg_wdata[15:0];
        REG_GAIN_D:          cfg_nxt.gain_d          = cfg_wdata[15:0];
        REG_INTEGRAL_WINDOW: cfg_nxt.integral_window = cfg_wdata;
        REG_SETTLE_BAND:     cfg_nxt.settle_band     = cfg_wdata;
        REG_SETTLE_MS:       cfg_nxt.settle_ms       = cfg_wdata[15:0];
        REG_TIMEOUT_MS:      cfg_nxt.timeout_ms      = cfg_wdata[15:0];
        REG_MAX_OUTPUT:      cfg_nxt.max_output      = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{max_output: MAX_OUTPUT_RST, default: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/psd_state_stage.sv =====
// ----------------------------------------------------------------------------
// psd_state_stage: input register and controller state update
// Registers the sample, then updates integral, last error and both timers
// in one pass and registers the values the drive arithmetic needs.
// ----------------------------------------------------------------------------
module psd_state_stage import psd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  err_t in_error,
  input  logic in_restart,
  output logic upd_valid,
  input  logic upd_ready,
  output upd_t upd
);

  logic        s0_v_r;
  err_t        s0_err_r;
  logic        s0_rst_r;
  logic        s1_v_r;
  upd_t        s1_r;
  upd_t        s1_nxt;

  logic signed [31:0] integ_r, integ_nxt;
  err_t               last_r;
  logic [15:0]        settled_r, settled_nxt;
  logic [15:0]        running_r, running_nxt;

  logic s0_adv, s1_adv, s0_fire;

  logic signed [31:0] cur_integ;
  err_t               cur_last;
  logic [15:0]        cur_settled;
  logic [15:0]        cur_running;
  logic [23:0]        err_mag;
  logic signed [32:0] integ_sum;
  logic signed [31:0] integ_sat;
  logic               sign_flip;

  function automatic logic [15:0] timer_step(input logic [15:0] t);
    logic [16:0] n;
    n = {1'b0, t} + {1'b0, TICK_MS};
    return (n > {1'b0, TIMER_MAX}) ? TIMER_MAX : n[15:0];
  endfunction

  assign s1_adv  = !s1_v_r || upd_ready;
  assign s0_adv  = !s0_v_r || s1_adv;
  assign s0_fire = s0_v_r && s1_adv;
  assign in_ready = s0_adv;

  always_comb begin
    cur_integ   = s0_rst_r ? '0 : integ_r;
    cur_last    = s0_rst_r ? '0 : last_r;
    cur_settled = s0_rst_r ? '0 : settled_r;
    cur_running = s0_rst_r ? '0 : running_r;

    // The most negative sample keeps its full magnitude in 24 bits.
    err_mag = s0_err_r[23] ? (24'd0 - s0_err_r) : s0_err_r;

    integ_sum = {cur_integ[31], cur_integ} + {{9{s0_err_r[23]}}, s0_err_r};
    if (integ_sum[32] != integ_sum[31]) begin
      integ_sat = integ_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      integ_sat = integ_sum[31:0];
    end

    integ_nxt = (err_mag < {1'b0, cfg.integral_window}) ? integ_sat : cur_integ;

    // A sign change against the previous sample empties the integral.
    sign_flip = (!s0_err_r[23] && (s0_err_r != '0) && cur_last[23]) ||
                (s0_err_r[23] && !cur_last[23] && (cur_last != '0));
    if (sign_flip) begin
      integ_nxt = '0;
    end

    settled_nxt = (err_mag < {1'b0, cfg.settle_band}) ? timer_step(cur_settled) : '0;
    running_nxt = timer_step(cur_running);

    s1_nxt.err   = s0_err_r;
    s1_nxt.integ = integ_nxt;
    s1_nxt.diff  = {s0_err_r[23], s0_err_r} - {cur_last[23], cur_last};
    s1_nxt.done  = ((cfg.timeout_ms != '0) && (running_nxt > cfg.timeout_ms)) ||
                   (settled_nxt > cfg.settle_ms);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r    <= 1'b0;
      s1_v_r    <= 1'b0;
      integ_r   <= '0;
      last_r    <= '0;
      settled_r <= '0;
      running_r <= '0;
    end else begin
      if (s0_adv) begin
        s0_v_r <= in_valid;
      end
      if (s1_adv) begin
        s1_v_r <= s0_v_r;
      end
      if (s0_fire) begin
        integ_r   <= integ_nxt;
        last_r    <= s0_err_r;
        settled_r <= settled_nxt;
        running_r <= running_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv && in_valid) begin
      s0_err_r <= in_error;
      s0_rst_r <= in_restart;
    end
    if (s0_fire) begin
      s1_r <= s1_nxt;
    end
  end

  assign upd_valid = s1_v_r;
  assign upd       = s1_r;

endmodule

// ===== src/psd_drive_stage.sv =====
// ----------------------------------------------------------------------------
// psd_drive_stage: drive arithmetic
// Forms the three gain products, then sums, rounds to Q.8 and clamps the
// drive into the output register.
// ----------------------------------------------------------------------------
module psd_drive_stage import psd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   upd_valid,
  output logic   upd_ready,
  input  upd_t   upd,
  output logic   out_valid,
  input  logic   out_ready,
  output drive_t out_drive,
  output logic   out_settled
);

  logic               s2_v_r;
  logic signed [40:0] p_r, p_nxt;
  logic signed [48:0] i_r, i_nxt;
  logic signed [41:0] d_r, d_nxt;
  logic               s2_done_r;

  logic               s3_v_r;
  drive_t             drive_r, drive_nxt;
  logic               settled_r;

  logic s2_adv, s3_adv;

  logic signed [50:0] sum;
  logic signed [42:0] rounded;
  logic signed [42:0] lim_pos;
  logic signed [42:0] lim_neg;
  logic signed [42:0] clamped;

  assign s3_adv    = !s3_v_r || out_ready;
  assign s2_adv    = !s2_v_r || s3_adv;
  assign upd_ready = s2_adv;

  always_comb begin
    p_nxt = $signed({1'b0, cfg.gain_p}) * $signed(upd.err);
    i_nxt = $signed({1'b0, cfg.gain_i}) * $signed(upd.integ);
    d_nxt = $signed({1'b0, cfg.gain_d}) * $signed(upd.diff);
  end

  always_comb begin
    sum = {{10{p_r[40]}}, p_r} + {{2{i_r[48]}}, i_r} + {{9{d_r[41]}}, d_r} + 51'sd128;
    // Arithmetic shift floors, so adding half a step first rounds half up.
    rounded = sum[50:8];
    lim_pos = $signed({20'd0, cfg.max_output});
    lim_neg = 43'sd0 - lim_pos;
    if (rounded > lim_pos) begin
      clamped = lim_pos;
    end else if (rounded < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = rounded;
    end
    drive_nxt = clamped[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s2_adv) begin
        s2_v_r <= upd_valid;
      end
      if (s3_adv) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && upd_valid) begin
      p_r       <= p_nxt;
      i_r       <= i_nxt;
      d_r       <= d_nxt;
      s2_done_r <= upd.done;
    end
    if (s3_adv && s2_v_r) begin
      drive_r   <= drive_nxt;
      settled_r <= s2_done_r;
    end
  end

  assign out_valid   = s3_v_r;
  assign out_drive   = drive_r;
  assign out_settled = settled_r;

endmodule

// ===== src/pid_with_settle_detect.sv =====
// ----------------------------------------------------------------------------
// pid_with_settle_detect: PID controller with integral window and settling
// Fixed-point PID step per error sample with saturated drive and a settled
// flag from settle and timeout timers.
// ----------------------------------------------------------------------------
// Usage:
//   One transaction on in_chan carries a signed Q15.8 error sample for one
//   10 ms control tick and a restart bit that clears the integral, the
//   previous error and both timers before that sample is used. Each input
//   transaction produces exactly one transaction on out_chan with the
//   saturated Q15.8 drive value and the settled flag.
//   The cfg_ port writes gains, windows, times and the drive limit by index;
//   write it only while no transaction is in flight.
//   The pipeline has four registered stages (input, state update, products,
//   rounding and clamp) and takes one transaction every cycle while
//   out_chan.ready stays high; the integral and timer feedback closes within
//   the state update stage.
//   Reset (rst_n low, synchronous) empties the pipeline, clears the state and
//   loads the register defaults, with a drive limit of 127.0.
//   When the receiver holds out_chan.ready low, the result stays in the
//   output register and each stage behind it keeps filling until all four
//   hold a transaction; only then does in_chan.ready go low.
// ----------------------------------------------------------------------------
module pid_with_settle_detect import psd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  psd_in_if.sink                in_chan,
  psd_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  logic upd_valid;
  logic upd_ready;
  upd_t upd;

  // Configuration registers, read live by both arithmetic stages.
  psd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register and the integral, last error and timer update.
  psd_state_stage u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_error   (in_chan.error_sample),
    .in_restart (in_chan.restart),
    .upd_valid  (upd_valid),
    .upd_ready  (upd_ready),
    .upd        (upd)
  );

  // Gain products, then rounding and clamping into the output register.
  psd_drive_stage u_drive (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .upd_valid   (upd_valid),
    .upd_ready   (upd_ready),
    .upd         (upd),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_drive   (out_chan.drive_value),
    .out_settled (out_chan.settled)
  );

endmodule

// ===== verif/pid_drive_checker.sv =====
// ----------------------------------------------------------------------------
// pid_drive_checker: drive and settled flag predictor and comparator
// Watches the sample, result and configuration ports of the PID block, keeps
// its own copy of the controller state, and checks every result transaction
// in order against the predicted drive value and settled flag.
// ----------------------------------------------------------------------------
module pid_drive_checker import psd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  psd_in_if                     in_mon,
  psd_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    open_results
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ACC_MAX = 64'sh7FFF_FFFF;
  localparam longint ACC_MIN = -64'sh8000_0000;

  typedef struct packed {
    drive_t drive;
    logic   settled;
  } pid_result_t;

  cfg_t               regs;
  logic signed [31:0] integ_acc;
  err_t               prev_err;
  logic [15:0]        settle_clk;
  logic [15:0]        run_clk;

  pid_result_t drive_expected[$];
  int          fault_tally = 0;
  int          pending_cnt = 0;

  assign mismatches   = fault_tally;
  assign open_results = pending_cnt;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fault_tally++;
  endtask

  function automatic logic [15:0] tick_ms(input logic [15:0] t);
    logic [16:0] n;
    n = {1'b0, t} + {1'b0, TICK_MS};
    return (n > {1'b0, TIMER_MAX}) ? TIMER_MAX : n[15:0];
  endfunction

  // One control tick: update the integral and timers, return drive and flag.
  task automatic pid_tick(input err_t e, input logic rs, output pid_result_t r);
    longint mag_e;
    longint acc;
    longint sum;
    longint dr;
    longint lim;
    if (rs) begin
      integ_acc  = '0;
      prev_err   = '0;
      settle_clk = '0;
      run_clk    = '0;
    end
    mag_e = (e < 0) ? -longint'(e) : longint'(e);
    // The sample is added first, then a sign change wipes the sum.
    if (mag_e < longint'(regs.integral_window)) begin
      acc = longint'(integ_acc) + longint'(e);
      if (acc > ACC_MAX) acc = ACC_MAX;
      if (acc < ACC_MIN) acc = ACC_MIN;
      integ_acc = acc[31:0];
    end
    if ((e > 0 && prev_err < 0) || (e < 0 && prev_err > 0)) begin
      integ_acc = '0;
    end
    sum = longint'(regs.gain_p) * longint'(e)
        + longint'(regs.gain_i) * longint'(integ_acc)
        + longint'(regs.gain_d) * (longint'(e) - longint'(prev_err));
    // Q.16 to Q.8, round half up; the arithmetic shift floors.
    dr  = (sum + 64'sd128) >>> 8;
    lim = longint'(regs.max_output);
    if (dr > lim) dr = lim;
    if (dr < -lim) dr = -lim;
    prev_err = e;
    if (mag_e < longint'(regs.settle_band)) begin
      settle_clk = tick_ms(settle_clk);
    end else begin
      settle_clk = '0;
    end
    run_clk   = tick_ms(run_clk);
    r.drive   = dr[23:0];
    r.settled = (regs.timeout_ms != 0 && run_clk > regs.timeout_ms) ||
                (settle_clk > regs.settle_ms);
  endtask

  always @(posedge clk) begin
    pid_result_t want;
    if (!rst_n) begin
      regs            = '0;
      regs.max_output = MAX_OUTPUT_RST;
      integ_acc       = '0;
      prev_err        = '0;
      settle_clk      = '0;
      run_clk         = '0;
      drive_expected.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_GAIN_P:          regs.gain_p          = cfg_wdata[15:0];
          REG_GAIN_I:          regs.gain_i          = cfg_wdata[15:0];
          REG_GAIN_D:          regs.gain_d          = cfg_wdata[15:0];
          REG_INTEGRAL_WINDOW: regs.integral_window = cfg_wdata[22:0];
          REG_SETTLE_BAND:     regs.settle_band     = cfg_wdata[22:0];
          REG_SETTLE_MS:       regs.settle_ms       = cfg_wdata[15:0];
          REG_TIMEOUT_MS:      regs.timeout_ms      = cfg_wdata[15:0];
          REG_MAX_OUTPUT:      regs.max_output      = cfg_wdata[22:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        pid_tick(in_mon.error_sample, in_mon.restart, want);
        drive_expected.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (drive_expected.size() == 0) begin
          report_mismatch($sformatf("result with none pending: drive %0d settled %0b",
                                    out_mon.drive_value, out_mon.settled));
        end else begin
          want = drive_expected.pop_front();
          if (out_mon.drive_value !== want.drive) begin
            report_mismatch($sformatf("drive_value %0d, predicted %0d",
                                      out_mon.drive_value, want.drive));
          end
          if (out_mon.settled !== want.settled) begin
            report_mismatch($sformatf("settled %0b, predicted %0b",
                                      out_mon.settled, want.settled));
          end
        end
      end
    end
    pending_cnt <= drive_expected.size();
  end

  final begin
    if (drive_expected.size() != 0) begin
      $display("%0d predicted results never arrived", drive_expected.size());
    end
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the PID controller with settle detection
// Drives error samples and register settings into the block, stalls both
// channels at random, and leaves prediction and comparison to the drive
// checker. Prints the verdict once every result has been accounted for.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import psd_pkg::*;

  // Cycles without any accepted transaction before the run is abandoned.
  // The worst honest gap is made of random stalls plus the register
  // programming and drain pauses between phases.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles allowed after the last result before a phase change or the end;
  // comfortably above the four-stage pipeline latency.
  localparam int DRAIN_CYCLES = 8;

  // Register sets. The typical set keeps the integral and settle windows
  // narrow so both sides of each comparison are hit often.
  localparam cfg_t CFG_TYPICAL = '{gain_p: 16'h0180, gain_i: 16'h0020, gain_d: 16'h0400,
                                   integral_window: 23'h002000, settle_band: 23'h000180,
                                   settle_ms: 16'd30, timeout_ms: 16'd0,
                                   max_output: 23'h007F00};
  // Everything at its ceiling: the integral can run into saturation.
  localparam cfg_t CFG_CEILING = '{gain_p: 16'hFFFF, gain_i: 16'hFFFF, gain_d: 16'hFFFF,
                                   integral_window: 23'h7FFFFF, settle_band: 23'h7FFFFF,
                                   settle_ms: 16'hFFFF, timeout_ms: 16'hFFFF,
                                   max_output: 23'h7FFFFF};
  // Windows and limit at zero, shortest possible timeout.
  localparam cfg_t CFG_FLOOR   = '{gain_p: 16'hFFFF, gain_i: 16'h0000, gain_d: 16'h0000,
                                   integral_window: 23'h000000, settle_band: 23'h000000,
                                   settle_ms: 16'd0, timeout_ms: 16'd1,
                                   max_output: 23'h000000};
  // Moderate gains with a drive limit that clips often and a live timeout.
  localparam cfg_t CFG_CLIPPED = '{gain_p: 16'h0100, gain_i: 16'h0100, gain_d: 16'h0100,
                                   integral_window: 23'h010000, settle_band: 23'h000800,
                                   settle_ms: 16'd100, timeout_ms: 16'd500,
                                   max_output: 23'h004000};
  // Long run without restart: the running timer passes the timeout late in
  // the run, so the flag rises only near its end.
  localparam cfg_t CFG_SOAK    = '{gain_p: 16'h0040, gain_i: 16'h0001, gain_d: 16'h0000,
                                   integral_window: 23'h7FFFFF, settle_band: 23'h7FFFFF,
                                   settle_ms: 16'hFFFF, timeout_ms: 16'd5000,
                                   max_output: 23'h7FFFFF};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fault_count;
  int open_results;
  int in_idle_pct;
  int out_idle_pct;
  int quiet_cycles;

  psd_in_if  in_chan ();
  psd_out_if out_chan ();

  pid_with_settle_detect DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  pid_drive_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (fault_count),
    .open_results (open_results)
  );

  always #10 clk = ~clk;

  // The result side drops ready at random, at the rate of the current phase.
  // A new decision is made every cycle, so stalls land on every pipeline
  // stage fill level.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Watchdog: the run is abandoned if no transaction moves on either
  // channel for too long. Valid and ready are sampled before this edge's
  // updates land, the same view the checker has.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offers one sample and returns at the edge where it is accepted. Random
  // idle cycles come first, with junk on the data lines while valid is low.
  // Valid gets a single assignment per edge, so back-to-back samples keep it
  // high without a glitch.
  task automatic put_sample(input err_t e, input bit rs);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid        <= 1'b0;
      in_chan.error_sample <= 24'($urandom);
      in_chan.restart      <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.error_sample <= e;
    in_chan.restart      <= rs;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Drops valid, waits until the checker holds no prediction, then lets the
  // pipeline run empty. Register writes are only safe after this.
  task automatic drain;
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_regs(input cfg_t c);
    write_reg(REG_GAIN_P,          CFG_DATA_W'(c.gain_p));
    write_reg(REG_GAIN_I,          CFG_DATA_W'(c.gain_i));
    write_reg(REG_GAIN_D,          CFG_DATA_W'(c.gain_d));
    write_reg(REG_INTEGRAL_WINDOW, c.integral_window);
    write_reg(REG_SETTLE_BAND,     c.settle_band);
    write_reg(REG_SETTLE_MS,       CFG_DATA_W'(c.settle_ms));
    write_reg(REG_TIMEOUT_MS,      CFG_DATA_W'(c.timeout_ms));
    write_reg(REG_MAX_OUTPUT,      c.max_output);
    cfg_we <= 1'b0;
  endtask

  // Random samples arranged in runs of one sign, which is what lets the
  // integral grow and the settle timer climb. Long runs of large same-sign
  // errors push the integral into saturation when the window allows it.
  // Some runs are pure noise or the field extremes, and a small share of
  // samples break the run with a zero or a sign flip.
  task automatic run_random(input int count, input int span, input bit with_restart);
    int          sent;
    int          run_len;
    int          kind;
    bit          neg;
    bit          rs;
    logic [22:0] m;
    err_t        e;
    sent = 0;
    while (sent < count) begin
      run_len = ($urandom_range(7) == 0) ? $urandom_range(300, 800) : $urandom_range(1, 30);
      neg     = 1'($urandom_range(1));
      kind    = $urandom_range(9);
      for (int k = 0; k < run_len && sent < count; k++) begin
        case (kind)
          0: e = 24'($urandom);
          1: begin
            case ($urandom_range(4))
              0:       e = 24'h7FFFFF;
              1:       e = 24'h800000;
              2:       e = 24'h000000;
              3:       e = 24'h000001;
              default: e = 24'hFFFFFF;
            endcase
          end
          2, 3, 4: begin
            m = 23'($urandom_range(span, span / 2));
            e = neg ? -err_t'(m) : err_t'(m);
          end
          default: begin
            m = 23'($urandom_range(span));
            e = neg ? -err_t'(m) : err_t'(m);
          end
        endcase
        if (kind >= 2) begin
          case ($urandom_range(15))
            0:       e = '0;
            1:       e = -e;
            default: ;
          endcase
        end
        rs = with_restart && ($urandom_range(59) == 0);
        put_sample(e, rs);
        sent++;
      end
    end
  endtask

  initial begin
    in_chan.valid        <= 1'b0;
    in_chan.error_sample <= '0;
    in_chan.restart      <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= REG_GAIN_P;
    cfg_wdata            <= '0;
    rst_n                <= 1'b0;
    // First idling profile: sender rarely idle, receiver mostly stalled,
    // so the pipeline fills and in_chan.ready gets pulled low.
    in_idle_pct  = 21;
    out_idle_pct = 72;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults straight out of reset: zero gains give zero drive,
    // and with a zero settle band the flag stays low.
    put_sample(24'h7FFFFF, 1'b0);
    put_sample(24'h800000, 1'b0);
    put_sample(24'h000000, 1'b0);
    drain();

    load_regs(CFG_TYPICAL);
    // Directed samples: restart, settle timer crossing settle_ms after four
    // ticks inside the band, sign change clearing the integral, both edges
    // of the integral window and settle band, field extremes including the
    // most negative sample, and a restart carried with a nonzero sample.
    put_sample(24'sd0, 1'b1);
    put_sample(24'sh000100, 1'b0);
    put_sample(24'sh000100, 1'b0);
    put_sample(24'sh000100, 1'b0);
    put_sample(24'sh000100, 1'b0);
    put_sample(-24'sd128, 1'b0);
    put_sample(24'sh001FFF, 1'b0);
    put_sample(24'sh002000, 1'b0);
    put_sample(24'sh00017F, 1'b0);
    put_sample(24'sh000180, 1'b0);
    put_sample(24'h7FFFFF, 1'b0);
    put_sample(24'h800000, 1'b0);
    put_sample(-24'sh7FFFFF, 1'b0);
    put_sample(24'sd1, 1'b0);
    put_sample(-24'sd1, 1'b0);
    put_sample(24'sd0, 1'b0);
    put_sample(24'sh000010, 1'b1);
    run_random(300, 'h3000, 1'b1);
    drain();

    load_regs(CFG_CEILING);
    run_random(400, 'h7FFFFF, 1'b1);
    drain();

    // Second idling profile: sender mostly idle, receiver rarely stalls.
    in_idle_pct  = 72;
    out_idle_pct = 21;
    load_regs(CFG_FLOOR);
    run_random(200, 'h400, 1'b1);
    drain();

    load_regs(CFG_CLIPPED);
    run_random(300, 'h20000, 1'b1);
    drain();

    // No idling at all: full-rate streaming for the timeout soak.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    load_regs(CFG_SOAK);
    run_random(600, 64, 1'b0);
    drain();

    load_regs(CFG_TYPICAL);
    run_random(150, 'h3000, 1'b1);
    drain();

    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
